FILE: rtl/scb_pkg.sv
// shared constants and helpers for the shell corotational basis pipeline
// no dependencies; the files that use it refer to it by scoped names
package scb_pkg;

  localparam int DIMS     = 3;
  localparam int COORD_W  = 32;
  localparam int AXIS_W   = 32;
  localparam int FRAC_W   = 30;
  localparam int SCALED_W = FRAC_W + 1;
  localparam int NORM_LAT = 66;

  localparam logic signed [63:0] ONE_Q30  = 64'sd1073741824;
  localparam logic [63:0]        HALF_Q30 = 64'd536870912;

  // divide by 2^30, round to nearest, ties away from zero
  function automatic logic signed [63:0] rnd30(input logic signed [63:0] n);
    logic [63:0] m;
    logic [63:0] r;
    m = n[63] ? 64'(-n) : 64'(n);
    r = (m + HALF_Q30) >> FRAC_W;
    return n[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [AXIS_W-1:0] sat_axis(input logic signed [63:0] t);
    logic signed [63:0] c;
    c = t;
    if (t > ONE_Q30) c = ONE_Q30;
    if (t < -ONE_Q30) c = -ONE_Q30;
    return AXIS_W'(c);
  endfunction

endpackage

FILE: rtl/scb_node_if.sv
// request channel carrying the four corner coordinates of one element
// depends on scb_pkg
interface scb_node_if;
  logic valid;
  logic ready;
  logic signed [scb_pkg::COORD_W-1:0] node0_x, node0_y, node0_z;
  logic signed [scb_pkg::COORD_W-1:0] node1_x, node1_y, node1_z;
  logic signed [scb_pkg::COORD_W-1:0] node2_x, node2_y, node2_z;
  logic signed [scb_pkg::COORD_W-1:0] node3_x, node3_y, node3_z;

  modport source (output valid, node0_x, node0_y, node0_z, node1_x, node1_y, node1_z,
                  node2_x, node2_y, node2_z, node3_x, node3_y, node3_z, input ready);
  modport sink (input valid, node0_x, node0_y, node0_z, node1_x, node1_y, node1_z,
                node2_x, node2_y, node2_z, node3_x, node3_y, node3_z, output ready);
endinterface

FILE: rtl/scb_frame_if.sv
// result channel carrying the local frame of one element
// depends on scb_pkg
interface scb_frame_if;
  logic valid;
  logic ready;
  logic signed [scb_pkg::AXIS_W-1:0] x_axis_x, x_axis_y, x_axis_z;
  logic signed [scb_pkg::AXIS_W-1:0] y_axis_x, y_axis_y, y_axis_z;
  logic signed [scb_pkg::AXIS_W-1:0] z_axis_x, z_axis_y, z_axis_z;
  logic degenerate;

  modport source (output valid, x_axis_x, x_axis_y, x_axis_z, y_axis_x, y_axis_y, y_axis_z,
                  z_axis_x, z_axis_y, z_axis_z, degenerate, input ready);
  modport sink (input valid, x_axis_x, x_axis_y, x_axis_z, y_axis_x, y_axis_y, y_axis_z,
                z_axis_x, z_axis_y, z_axis_z, degenerate, output ready);
endinterface

FILE: rtl/scb_delay.sv
// enabled shift register that carries side data alongside the pipeline
// no package dependencies
module scb_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  logic [W-1:0] sr [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int i = 1; i < DEPTH; i++) sr[i] <= sr[i-1];
    end
  end

  assign q = sr[DEPTH-1];
endmodule

FILE: rtl/scb_scale.sv
// two-stage block scaling of a 3-vector so its largest magnitude has 30 bits
// depends on scb_pkg
module scb_scale #(
  parameter int W = 33
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [W-1:0]                  a [scb_pkg::DIMS],
  output logic signed [scb_pkg::SCALED_W-1:0]  y [scb_pkg::DIMS],
  output logic                                 nz
);
  localparam int BW = $clog2(W + 1);
  localparam int FW = scb_pkg::FRAC_W;

  logic [W-1:0]              mag_c [scb_pkg::DIMS];
  logic [W-1:0]              mag   [scb_pkg::DIMS];
  logic [scb_pkg::DIMS-1:0]  neg;
  logic [W-1:0]              orv;
  logic [W-1:0]              orv_c;
  logic [BW-1:0]             blen;
  logic [W+FW-1:0]           wide  [scb_pkg::DIMS];
  logic signed [scb_pkg::SCALED_W-1:0] y_next [scb_pkg::DIMS];

  always_comb begin
    orv_c = '0;
    for (int i = 0; i < scb_pkg::DIMS; i++) begin
      mag_c[i] = a[i][W-1] ? W'(-a[i]) : W'(a[i]);
      orv_c    = orv_c | mag_c[i];
    end
  end

  // bit length of the largest magnitude equals that of the or of all of them
  always_comb begin
    blen = '0;
    for (int k = 0; k < W; k++) if (orv[k]) blen = BW'(k + 1);
    for (int i = 0; i < scb_pkg::DIMS; i++) begin
      wide[i]   = {mag[i], FW'(0)} >> blen;
      y_next[i] = neg[i] ? -$signed({1'b0, wide[i][FW-1:0]}) : $signed({1'b0, wide[i][FW-1:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < scb_pkg::DIMS; i++) begin
        mag[i] <= mag_c[i];
        neg[i] <= a[i][W-1];
        y[i]   <= y_next[i];
      end
      orv <= orv_c;
      nz  <= |orv;
    end
  end
endmodule

FILE: rtl/scb_norm.sv
// pipelined normalizer: squares, sum, 32-step square root, 31-step divide per lane
// depends on scb_pkg
module scb_norm (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [scb_pkg::SCALED_W-1:0] v [scb_pkg::DIMS],
  output logic signed [scb_pkg::AXIS_W-1:0]   u [scb_pkg::DIMS]
);
  localparam int FW       = scb_pkg::FRAC_W;
  localparam int SQ_STEPS = 32;
  localparam int DV_STEPS = FW + 1;
  localparam int LEN_W    = FW + 1;
  localparam int DEN_W    = LEN_W + 1;
  localparam int REM_W    = 2 * FW + 3;

  logic [FW-1:0]             m_c  [scb_pkg::DIMS];
  logic [FW-1:0]             m1   [scb_pkg::DIMS];
  logic [2*FW-1:0]           q1   [scb_pkg::DIMS];
  logic [scb_pkg::DIMS-1:0]  n1;

  logic [63:0]               sq_s [SQ_STEPS+1];
  logic [63:0]               sq_r [SQ_STEPS+1];
  logic [FW-1:0]             sq_m [SQ_STEPS+1][scb_pkg::DIMS];
  logic [scb_pkg::DIMS-1:0]  sq_n [SQ_STEPS+1];
  logic [63:0]               s_nx [SQ_STEPS];
  logic [63:0]               r_nx [SQ_STEPS];

  logic [REM_W-1:0]          dv_rem [DV_STEPS][scb_pkg::DIMS];
  logic [FW:0]               dv_q   [DV_STEPS][scb_pkg::DIMS];
  logic [DEN_W-1:0]          dv_d   [DV_STEPS];
  logic [scb_pkg::DIMS-1:0]  dv_n   [DV_STEPS];
  logic [REM_W-1:0]          in_rem [DV_STEPS][scb_pkg::DIMS];
  logic [FW:0]               in_q   [DV_STEPS][scb_pkg::DIMS];
  logic [DEN_W-1:0]          in_d   [DV_STEPS];
  logic [scb_pkg::DIMS-1:0]  in_n   [DV_STEPS];
  logic [REM_W-1:0]          nx_rem [DV_STEPS][scb_pkg::DIMS];
  logic [FW:0]               nx_q   [DV_STEPS][scb_pkg::DIMS];
  logic [REM_W-1:0]          dsh    [DV_STEPS];
  logic [LEN_W-1:0]          len;

  always_comb begin
    for (int i = 0; i < scb_pkg::DIMS; i++)
      m_c[i] = v[i][scb_pkg::SCALED_W-1] ? FW'(-v[i]) : FW'(v[i]);
  end

  // one root bit per stage
  always_comb begin
    for (int j = 0; j < SQ_STEPS; j++) begin
      if (sq_s[j] >= sq_r[j] + (64'd1 << (62 - 2 * j))) begin
        s_nx[j] = sq_s[j] - (sq_r[j] + (64'd1 << (62 - 2 * j)));
        r_nx[j] = (sq_r[j] >> 1) + (64'd1 << (62 - 2 * j));
      end else begin
        s_nx[j] = sq_s[j];
        r_nx[j] = sq_r[j] >> 1;
      end
    end
  end

  assign len = LEN_W'(sq_r[SQ_STEPS]);

  // restoring divide, one quotient bit per stage, numerator 2*m*2^30 + len over 2*len
  always_comb begin
    for (int k = 0; k < DV_STEPS; k++) begin
      if (k == 0) begin
        in_d[k] = {len, 1'b0};
        in_n[k] = sq_n[SQ_STEPS];
        for (int i = 0; i < scb_pkg::DIMS; i++) begin
          in_rem[k][i] = REM_W'({sq_m[SQ_STEPS][i], (FW + 1)'(0)}) + REM_W'(len);
          in_q[k][i]   = '0;
        end
      end else begin
        in_d[k] = dv_d[k-1];
        in_n[k] = dv_n[k-1];
        for (int i = 0; i < scb_pkg::DIMS; i++) begin
          in_rem[k][i] = dv_rem[k-1][i];
          in_q[k][i]   = dv_q[k-1][i];
        end
      end
      dsh[k] = REM_W'(in_d[k]) << (FW - k);
      for (int i = 0; i < scb_pkg::DIMS; i++) begin
        nx_rem[k][i] = in_rem[k][i];
        nx_q[k][i]   = in_q[k][i];
        if (in_rem[k][i] >= dsh[k]) begin
          nx_rem[k][i]        = in_rem[k][i] - dsh[k];
          nx_q[k][i][FW - k]  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < scb_pkg::DIMS; i++) begin
        m1[i] <= m_c[i];
        n1[i] <= v[i][scb_pkg::SCALED_W-1];
        q1[i] <= m_c[i] * m_c[i];
      end
      sq_s[0] <= 64'(q1[0]) + 64'(q1[1]) + 64'(q1[2]);
      sq_r[0] <= '0;
      sq_m[0] <= m1;
      sq_n[0] <= n1;
      for (int j = 0; j < SQ_STEPS; j++) begin
        sq_s[j+1] <= s_nx[j];
        sq_r[j+1] <= r_nx[j];
        sq_m[j+1] <= sq_m[j];
        sq_n[j+1] <= sq_n[j];
      end
      for (int k = 0; k < DV_STEPS; k++) begin
        dv_d[k]   <= in_d[k];
        dv_n[k]   <= in_n[k];
        dv_rem[k] <= nx_rem[k];
        dv_q[k]   <= nx_q[k];
      end
      for (int i = 0; i < scb_pkg::DIMS; i++)
        u[i] <= dv_n[DV_STEPS-1][i] ? -$signed({1'b0, dv_q[DV_STEPS-1][i]})
                                    : $signed({1'b0, dv_q[DV_STEPS-1][i]});
    end
  end
endmodule

FILE: rtl/shell_corotational_basis_core.sv
// channel     dir  payload
// node_in     in   four corners, twelve signed q16.16 coordinates
// frame_out   out  three q1.30 unit axes and the degenerate flag
//
// one element accepted per cycle while the pipeline advances; the pipeline holds
// two normalizers (32-step root and 31-step divide each)
// rst is synchronous and clears only the valid bits
// the whole pipeline advances when the output register is empty or taken;
// a stall freezes every stage, so nothing is lost or repeated
// depends on scb_pkg, scb_node_if, scb_frame_if, scb_delay, scb_scale, scb_norm
module shell_corotational_basis_core (
  input logic        clk,
  input logic        rst,
  scb_node_if.sink   node_in,
  scb_frame_if.source frame_out
);
  localparam int NL  = scb_pkg::NORM_LAT;
  localparam int LAT = 83 + NL;
  localparam int D   = scb_pkg::DIMS;
  localparam int SW  = scb_pkg::SCALED_W;
  localparam int AW  = scb_pkg::AXIS_W;
  localparam int CW  = scb_pkg::COORD_W;

  logic [LAT-1:0] vpipe;
  logic           adv;

  logic signed [CW-1:0]  nd [4][D];
  logic signed [CW:0]    d31 [D], d42 [D], d21 [D];
  logic signed [SW-1:0]  r31s [D], r42s [D], r21s [D], r21d [D], r21b [D];
  logic signed [61:0]    c1p [6];
  logic signed [61:0]    s33 [D];
  logic signed [SW-1:0]  s33s [D];
  logic                  nz1, nz1d, nz2;
  logic signed [AW-1:0]  e3 [D], e3a [D], e3b [D], e1 [D];
  logic signed [63:0]    dp [D];
  logic signed [63:0]    dsum;
  logic signed [CW:0]    p;
  logic signed [63:0]    pe [D];
  logic signed [CW+1:0]  s11 [D];
  logic signed [SW-1:0]  s11s [D];
  logic                  deg_a, deg_b;
  logic signed [63:0]    e2p [6];
  logic signed [63:0]    e2d [D];
  logic signed [AW-1:0]  e1c [2][D], e3c [2][D];
  logic [1:0]            degc;

  logic [D*SW-1:0] r21s_w, r21d_w, r21b_w;
  logic [D*AW-1:0] e3_w, e3a_w, e3b_w;

  logic signed [AW-1:0] o_x [D], o_y [D], o_z [D];
  logic                 o_deg;

  assign adv           = !vpipe[LAT-1] || frame_out.ready;
  assign node_in.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (adv) begin
      vpipe <= {vpipe[LAT-2:0], node_in.valid};
    end
  end

  always_comb begin
    nd[0][0] = node_in.node0_x; nd[0][1] = node_in.node0_y; nd[0][2] = node_in.node0_z;
    nd[1][0] = node_in.node1_x; nd[1][1] = node_in.node1_y; nd[1][2] = node_in.node1_z;
    nd[2][0] = node_in.node2_x; nd[2][1] = node_in.node2_y; nd[2][2] = node_in.node2_z;
    nd[3][0] = node_in.node3_x; nd[3][1] = node_in.node3_y; nd[3][2] = node_in.node3_z;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < D; i++) begin
        d31[i] <= {nd[2][i][CW-1], nd[2][i]} - {nd[0][i][CW-1], nd[0][i]};
        d42[i] <= {nd[3][i][CW-1], nd[3][i]} - {nd[1][i][CW-1], nd[1][i]};
        d21[i] <= {nd[1][i][CW-1], nd[1][i]} - {nd[0][i][CW-1], nd[0][i]};
      end
    end
  end

  scb_scale #(.W(CW + 1)) u_sc31 (.clk(clk), .en(adv), .a(d31), .y(r31s), .nz());
  scb_scale #(.W(CW + 1)) u_sc42 (.clk(clk), .en(adv), .a(d42), .y(r42s), .nz());
  scb_scale #(.W(CW + 1)) u_sc21 (.clk(clk), .en(adv), .a(d21), .y(r21s), .nz());

  // normal: cross product of the diagonals
  always_ff @(posedge clk) begin
    if (adv) begin
      c1p[0] <= r31s[1] * r42s[2];
      c1p[1] <= r31s[2] * r42s[1];
      c1p[2] <= r31s[2] * r42s[0];
      c1p[3] <= r31s[0] * r42s[2];
      c1p[4] <= r31s[0] * r42s[1];
      c1p[5] <= r31s[1] * r42s[0];
      s33[0] <= c1p[0] - c1p[1];
      s33[1] <= c1p[2] - c1p[3];
      s33[2] <= c1p[4] - c1p[5];
    end
  end

  scb_scale #(.W(62)) u_sc33 (.clk(clk), .en(adv), .a(s33), .y(s33s), .nz(nz1));
  scb_norm u_norm3 (.clk(clk), .en(adv), .v(s33s), .u(e3));

  always_comb begin
    for (int i = 0; i < D; i++) begin
      r21s_w[i*SW +: SW] = r21s[i];
      r21d[i]            = r21d_w[i*SW +: SW];
      r21b[i]            = r21b_w[i*SW +: SW];
      e3_w[i*AW +: AW]   = e3[i];
      e3a[i]             = e3a_w[i*AW +: AW];
      e3b[i]             = e3b_w[i*AW +: AW];
    end
  end

  scb_delay #(.W(D*SW), .DEPTH(NL + 4)) u_dl_r21a (.clk(clk), .en(adv), .d(r21s_w), .q(r21d_w));
  scb_delay #(.W(D*SW), .DEPTH(4))      u_dl_r21b (.clk(clk), .en(adv), .d(r21d_w), .q(r21b_w));
  scb_delay #(.W(1), .DEPTH(NL))        u_dl_nz1  (.clk(clk), .en(adv), .d(nz1), .q(nz1d));
  scb_delay #(.W(D*AW), .DEPTH(3))      u_dl_e3a  (.clk(clk), .en(adv), .d(e3_w), .q(e3a_w));
  scb_delay #(.W(D*AW), .DEPTH(NL + 4)) u_dl_e3b  (.clk(clk), .en(adv), .d(e3a_w), .q(e3b_w));
  scb_delay #(.W(1), .DEPTH(7))         u_dl_dga  (.clk(clk), .en(adv), .d(!nz1d), .q(deg_a));
  scb_delay #(.W(1), .DEPTH(NL))        u_dl_dgb  (.clk(clk), .en(adv), .d(deg_a || !nz2),
                                                   .q(deg_b));

  // project the edge off the fresh normal
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < D; i++) dp[i] <= r21d[i] * e3[i];
      dsum <= dp[0] + dp[1] + dp[2];
      p    <= (CW + 1)'(scb_pkg::rnd30(dsum));
      for (int i = 0; i < D; i++) begin
        pe[i]  <= p * e3a[i];
        s11[i] <= (CW + 2)'(r21b[i]) - (CW + 2)'(scb_pkg::rnd30(pe[i]));
      end
    end
  end

  scb_scale #(.W(CW + 2)) u_sc11 (.clk(clk), .en(adv), .a(s11), .y(s11s), .nz(nz2));
  scb_norm u_norm1 (.clk(clk), .en(adv), .v(s11s), .u(e1));

  // e2 = e3 x e1, then round, saturate and zero on degenerate
  always_ff @(posedge clk) begin
    if (adv) begin
      e2p[0] <= e3b[1] * e1[2];
      e2p[1] <= e3b[2] * e1[1];
      e2p[2] <= e3b[2] * e1[0];
      e2p[3] <= e3b[0] * e1[2];
      e2p[4] <= e3b[0] * e1[1];
      e2p[5] <= e3b[1] * e1[0];
      e2d[0] <= e2p[0] - e2p[1];
      e2d[1] <= e2p[2] - e2p[3];
      e2d[2] <= e2p[4] - e2p[5];
      e1c[0] <= e1;
      e3c[0] <= e3b;
      e1c[1] <= e1c[0];
      e3c[1] <= e3c[0];
      degc   <= {degc[0], deg_b};
      o_deg  <= degc[1];
      for (int i = 0; i < D; i++) begin
        o_x[i] <= degc[1] ? '0 : e1c[1][i];
        o_y[i] <= degc[1] ? '0 : scb_pkg::sat_axis(scb_pkg::rnd30(e2d[i]));
        o_z[i] <= degc[1] ? '0 : e3c[1][i];
      end
    end
  end

  assign frame_out.valid      = vpipe[LAT-1];
  assign frame_out.x_axis_x   = o_x[0];
  assign frame_out.x_axis_y   = o_x[1];
  assign frame_out.x_axis_z   = o_x[2];
  assign frame_out.y_axis_x   = o_y[0];
  assign frame_out.y_axis_y   = o_y[1];
  assign frame_out.y_axis_z   = o_y[2];
  assign frame_out.z_axis_x   = o_z[0];
  assign frame_out.z_axis_y   = o_z[1];
  assign frame_out.z_axis_z   = o_z[2];
  assign frame_out.degenerate = o_deg;
endmodule

FILE: rtl/scb_checker.sv
// port-level checks for shell_corotational_basis_core, attached by bind
// depends on scb_pkg and the top level's interface ports
module scb_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              degenerate,
  input logic signed [scb_pkg::AXIS_W-1:0] xx, xy, xz,
  input logic signed [scb_pkg::AXIS_W-1:0] zx, zy, zz
);
  // requests are taken exactly when the output slot frees up
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready)) else $error("ready does not follow output slot");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(degenerate) && $stable(zx) && $stable(xx))
    else $error("stalled result changed");

  a_degen: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> xx == 0 && xy == 0 && xz == 0 && zx == 0 && zy == 0 && zz == 0)
    else $error("degenerate result not zeroed");

  a_normal: assert property (@(posedge clk) disable iff (rst)
    out_valid && !degenerate |-> zx != 0 || zy != 0 || zz != 0)
    else $error("zero normal without degenerate flag");

  // first cycle out of reset shows no result
  a_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid) else $error("result valid right after reset");
endmodule

bind shell_corotational_basis_core scb_checker u_scb_checker (
  .clk(clk), .rst(rst),
  .in_ready(node_in.ready), .out_valid(frame_out.valid), .out_ready(frame_out.ready),
  .degenerate(frame_out.degenerate),
  .xx(frame_out.x_axis_x), .xy(frame_out.x_axis_y), .xz(frame_out.x_axis_z),
  .zx(frame_out.z_axis_x), .zy(frame_out.z_axis_y), .zz(frame_out.z_axis_z)
);

FILE: sim/scb_tb_if.sv
// note: the channel interfaces are provided by the rtl (scb_node_if, scb_frame_if)
// this file holds the request and frame structs shared by the testbench modules
// no package dependencies
package scb_tb_pkg;
  typedef struct packed {
    logic signed [31:0] n0x, n0y, n0z, n1x, n1y, n1z, n2x, n2y, n2z, n3x, n3y, n3z;
  } corners_t;
  typedef struct packed {
    logic signed [31:0] e1x, e1y, e1z, e2x, e2y, e2z, e3x, e3y, e3z;
    logic degen;
  } frame_t;
endpackage

FILE: sim/scb_frame_checker.sv
// checker: watches both channels, predicts the element frame and compares
// depends on scb_tb_pkg, scb_node_if, scb_frame_if
module scb_frame_checker (
  input  logic    clk,
  input  logic    rst,
  scb_node_if     node_ch,
  scb_frame_if    frame_ch,
  output int      errors,
  output int      pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import scb_tb_pkg::*;

  frame_t frames_due[$];

  function automatic longint absv(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint rnd_q30(longint n);
    longint m;
    m = (absv(n) + 64'sd536870912) >>> 30;
    return n < 0 ? -m : m;
  endfunction

  function automatic int bits_of(longint m);
    int b;
    b = 0;
    while (m != 0) begin
      b++;
      m = m >>> 1;
    end
    return b;
  endfunction

  // block-scale so the largest magnitude has exactly 30 bits; 0 if zero vector
  function automatic bit fit30(inout longint v[3]);
    longint mx, m;
    int b;
    mx = 0;
    foreach (v[i]) if (absv(v[i]) > mx) mx = absv(v[i]);
    if (mx == 0) return 0;
    b = bits_of(mx);
    foreach (v[i]) begin
      m = absv(v[i]);
      if (b > 30) m = m >>> (b - 30);
      else if (b < 30) m = m << (30 - b);
      v[i] = v[i] < 0 ? -m : m;
    end
    return 1;
  endfunction

  function automatic longint root_floor(longint unsigned s);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > s) bt = bt >> 2;
    while (bt != 0) begin
      if (s >= res + bt) begin
        s -= res + bt;
        res = (res >> 1) + bt;
      end else res = res >> 1;
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic void unit_vec(longint v[3], output longint u[3]);
    longint unsigned s, len, m;
    s = 0;
    foreach (v[i]) s += absv(v[i]) * absv(v[i]);
    len = root_floor(s);
    foreach (v[i]) begin
      m = absv(v[i]) << 30;
      m = (2 * m + len) / (2 * len);
      u[i] = v[i] < 0 ? -longint'(m) : longint'(m);
    end
  endfunction

  function automatic void cross3(longint a[3], longint b[3], output longint c[3]);
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic frame_t element_frame(corners_t c);
    frame_t f;
    longint d31[3], d42[3], d21[3], nrm[3], edg[3], e1[3], e2[3], e3[3];
    longint dt, p, t;
    f = '0;
    d31 = '{longint'(c.n2x) - c.n0x, longint'(c.n2y) - c.n0y, longint'(c.n2z) - c.n0z};
    d42 = '{longint'(c.n3x) - c.n1x, longint'(c.n3y) - c.n1y, longint'(c.n3z) - c.n1z};
    d21 = '{longint'(c.n1x) - c.n0x, longint'(c.n1y) - c.n0y, longint'(c.n1z) - c.n0z};
    void'(fit30(d31));
    void'(fit30(d42));
    cross3(d31, d42, nrm);
    if (!fit30(nrm)) begin
      f.degen = 1'b1;
      return f;
    end
    unit_vec(nrm, e3);
    void'(fit30(d21));
    dt = 0;
    foreach (d21[i]) dt += d21[i] * e3[i];
    p = rnd_q30(dt);
    foreach (d21[i]) edg[i] = d21[i] - rnd_q30(p * e3[i]);
    if (!fit30(edg)) begin
      f.degen = 1'b1;
      return f;
    end
    unit_vec(edg, e1);
    cross3(e3, e1, e2);
    foreach (e2[i]) begin
      t = rnd_q30(e2[i]);
      if (t > 64'sd1073741824) t = 64'sd1073741824;
      if (t < -64'sd1073741824) t = -64'sd1073741824;
      e2[i] = t;
    end
    f.e1x = 32'(e1[0]); f.e1y = 32'(e1[1]); f.e1z = 32'(e1[2]);
    f.e2x = 32'(e2[0]); f.e2y = 32'(e2[1]); f.e2z = 32'(e2[2]);
    f.e3x = 32'(e3[0]); f.e3y = 32'(e3[1]); f.e3z = 32'(e3[2]);
    return f;
  endfunction

  frame_t got, want;
  corners_t req;

  assign pending = frames_due.size();

  always @(posedge clk) begin
    if (rst) begin
      errors <= 0;
    end else begin
      if (node_ch.valid && node_ch.ready) begin
        req = '{node_ch.node0_x, node_ch.node0_y, node_ch.node0_z,
                node_ch.node1_x, node_ch.node1_y, node_ch.node1_z,
                node_ch.node2_x, node_ch.node2_y, node_ch.node2_z,
                node_ch.node3_x, node_ch.node3_y, node_ch.node3_z};
        frames_due.push_back(element_frame(req));
      end
      if (frame_ch.valid && frame_ch.ready) begin
        got = '{frame_ch.x_axis_x, frame_ch.x_axis_y, frame_ch.x_axis_z,
                frame_ch.y_axis_x, frame_ch.y_axis_y, frame_ch.y_axis_z,
                frame_ch.z_axis_x, frame_ch.z_axis_y, frame_ch.z_axis_z,
                frame_ch.degenerate};
        if (frames_due.size() == 0) begin
          if (errors < 10) $display("unexpected frame %h", got);
          errors <= errors + 1;
        end else begin
          want = frames_due.pop_front();
          if (got !== want) begin
            if (errors < 10)
              $display("frame mismatch: expected %h, got %h", want, got);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

FILE: sim/tb_shell_corotational_basis_core.sv
// top: clock, reset, element stimulus, verdict
// depends on scb_tb_pkg, the channel interfaces, the core and the checker
module tb_shell_corotational_basis_core;
  timeunit 1ns;
  timeprecision 1ps;
  import scb_tb_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int errors, pending, quiet;
  bit calm, hold_off;

  scb_node_if  node_ch();
  scb_frame_if frame_ch();

  shell_corotational_basis_core u_top (
    .clk(clk), .rst(rst), .node_in(node_ch.sink), .frame_out(frame_ch.source));

  scb_frame_checker u_chk (
    .clk(clk), .rst(rst), .node_ch(node_ch), .frame_ch(frame_ch),
    .errors(errors), .pending(pending));

  always #10 clk = ~clk;

  // receiver side: random stalls, a calm stretch, one long hold-off
  always @(negedge clk) begin
    if (rst || hold_off) frame_ch.ready <= 1'b0;
    else frame_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 24);
  end

  // watchdog on accepted traffic
  always @(posedge clk) begin
    if (!rst && ((node_ch.valid && node_ch.ready) || (frame_ch.valid && frame_ch.ready)))
      quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3: return $signed($urandom_range(2047)) - 1024;
      default: return $signed($urandom);
    endcase
  endfunction

  corners_t c;

  task automatic offer(corners_t k);
    if (!calm)
      while ($urandom_range(99) < 24) @(negedge clk);
    {node_ch.node0_x, node_ch.node0_y, node_ch.node0_z, node_ch.node1_x,
     node_ch.node1_y, node_ch.node1_z, node_ch.node2_x, node_ch.node2_y,
     node_ch.node2_z, node_ch.node3_x, node_ch.node3_y, node_ch.node3_z} = k;
    node_ch.valid = 1'b1;
    @(posedge clk);
    while (!node_ch.ready) @(posedge clk);
    @(negedge clk);
    node_ch.valid = 1'b0;
  endtask

  // well-formed flat-ish quad around a random center with random size
  function automatic corners_t quad();
    corners_t q;
    int sz;
    logic signed [31:0] cx, cy, cz;
    sz = $urandom_range(20, 4);
    cx = $signed($urandom) >>> 2; cy = $signed($urandom) >>> 2; cz = $signed($urandom) >>> 2;
    q.n0x = cx; q.n0y = cy; q.n0z = cz + ($signed($urandom) >>> (34 - sz));
    q.n1x = cx + (1 << sz); q.n1y = cy + ($signed($urandom) >>> (33 - sz)); q.n1z = cz;
    q.n2x = cx + (1 << sz); q.n2y = cy + (1 << sz); q.n2z = cz + ($signed($urandom) >>> (34 - sz));
    q.n3x = cx + ($signed($urandom) >>> (33 - sz)); q.n3y = cy + (1 << sz); q.n3z = cz;
    return q;
  endfunction

  initial begin
    node_ch.valid = 1'b0;
    {node_ch.node0_x, node_ch.node0_y, node_ch.node0_z, node_ch.node1_x,
     node_ch.node1_y, node_ch.node1_z, node_ch.node2_x, node_ch.node2_y,
     node_ch.node2_z, node_ch.node3_x, node_ch.node3_y, node_ch.node3_z} = '0;
    calm = 0; hold_off = 0;
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // unit square in the xy plane
    offer('{0, 0, 0, 32'sh10000, 0, 0, 32'sh10000, 32'sh10000, 0, 0, 32'sh10000, 0});
    // all corners equal: zero normal
    offer('{5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5});
    // parallel diagonals
    offer('{0, 0, 0, 1, 1, 1, 2, 2, 2, 3, 3, 3});
    // edge out of the plane of the diagonals: nonzero projected edge
    offer('{0, 0, 0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000, 0, 0, 32'sh10000, 0});
    // zero edge with a good normal
    offer('{0, 0, 0, 0, 0, 0, 32'sh10000, 32'sh10000, 0, 32'sh10000, 0, 0});
    // extreme corners
    offer('{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
            32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
            32'sh7fffffff, 32'sh7fffffff});
    offer('{32'sh7fffffff, 0, 32'sh80000000, 0, 32'sh7fffffff, 0, 32'sh80000000, 0,
            32'sh7fffffff, 0, 32'sh80000000, 32'sh7fffffff});
    offer('{-1, -1, -1, 0, -1, -1, 0, 0, -1, -1, 0, -1});
    repeat (8) begin
      c = {pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
           pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord()};
      offer(c);
    end

    // sender pauses until all frames have returned
    wait (pending == 0);

    // long receiver hold-off while requests keep coming, so the core backs up
    @(negedge clk) hold_off <= 1'b1;
    fork
      begin
        repeat (400) @(negedge clk);
        hold_off <= 1'b0;
      end
      repeat (200) offer(quad());
    join

    for (int n = 0; n < 1000; n++) begin
      calm = (n >= 400 && n < 600);
      case ($urandom_range(9))
        0, 1: begin
          c = {pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
               pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
               pick_coord(), pick_coord()};
          offer(c);
        end
        2: begin
          c = quad();
          c.n1x = c.n0x; c.n1y = c.n0y; c.n1z = c.n0z;
          offer(c);
        end
        default: offer(quad());
      endcase
    end
    calm = 0;

    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
